@@ design/spd_pkg.sv @@
// shared types, constants and helpers for the peak-per-pixel decimator
// no dependencies; imported by every module of the block
`default_nettype none

package spd_pkg;

    // default widths of the sample countdown and the column counter
    localparam int COUNT_BITS_DEF  = 32;
    localparam int COLUMN_BITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_COUNT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_STEP  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE = 4'd3;

    // item operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    localparam logic [14:0] PEAK_MAX     = 15'h7fff;
    localparam logic [15:0] PCM_MIN_CODE = 16'h8000;
    localparam int          ACC_W        = 17;

    // column geometry and channel mode
    typedef struct packed {
        logic [15:0] extra_step;
        logic [15:0] image_width;
        logic        stereo_mode;
    } t_cfg;

    // one input item
    typedef struct packed {
        logic        operation;
        logic [15:0] left_sample;
        logic [15:0] right_sample;
    } t_in_item;

    // absolute value of a pcm code, the most negative code saturating
    function automatic logic [14:0] pcm_magnitude(input logic [15:0] code);
        logic [15:0] neg;
        neg = 16'h0000 - code;
        if (code == PCM_MIN_CODE) begin
            return PEAK_MAX;
        end else if (code[15]) begin
            return neg[14:0];
        end else begin
            return code[14:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ design/spd_cfg_regs.sv @@
// configuration registers of the decimator
// depends on spd_pkg
`default_nettype none

module spd_cfg_regs #(
    parameter int COUNT_BITS = spd_pkg::COUNT_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr,
    input  wire logic [spd_pkg::CFG_IDX_W-1:0]  i_index,
    input  wire logic [spd_pkg::CFG_DATA_W-1:0] i_data,
    output logic      [COUNT_BITS-1:0]          o_base_count,
    output spd_pkg::t_cfg                       o_cfg
);
    import spd_pkg::*;

    logic [COUNT_BITS-1:0]            r_base_count;
    t_cfg                             r_cfg;
    logic [COUNT_BITS+CFG_DATA_W-1:0] base_ext;

    // zero-extend then keep the low count bits
    assign base_ext = {{COUNT_BITS{1'b0}}, i_data};

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_count      <= COUNT_BITS'(1);
            r_cfg.extra_step  <= 16'd0;
            r_cfg.image_width <= 16'd1;
            r_cfg.stereo_mode <= 1'b1;
        end else if (i_wr) begin
            case (i_index)
                REG_BASE_COUNT:  r_base_count      <= base_ext[COUNT_BITS-1:0];
                REG_EXTRA_STEP:  r_cfg.extra_step  <= i_data[15:0];
                REG_IMAGE_WIDTH: r_cfg.image_width <= i_data[15:0];
                REG_STEREO_MODE: r_cfg.stereo_mode <= i_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_base_count = r_base_count;
    assign o_cfg        = r_cfg;

endmodule

`default_nettype wire

@@ design/spd_in_stage.sv @@
// input register of the decimator, holds one item until the core takes it
// depends on spd_pkg
`default_nettype none

module spd_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  spd_pkg::t_in_item      i_item,
    output logic                   o_valid,
    output spd_pkg::t_in_item      o_item,
    input  wire logic              i_taken
);
    import spd_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // free when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ design/spd_peak_core.sv @@
// peak tracking and column sequencing state with its update logic
// depends on spd_pkg
`default_nettype none

module spd_peak_core #(
    parameter int COUNT_BITS  = spd_pkg::COUNT_BITS_DEF,
    parameter int COLUMN_BITS = spd_pkg::COLUMN_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [COUNT_BITS-1:0]  i_base_count,
    input  spd_pkg::t_cfg               i_cfg,
    input  wire logic                   i_valid,
    input  spd_pkg::t_in_item           i_item,
    input  wire logic                   i_out_free,
    output logic                        o_taken,
    output logic                        o_emit,
    output logic      [COLUMN_BITS-1:0] o_column,
    output logic      [14:0]            o_left_peak,
    output logic      [14:0]            o_right_peak
);
    import spd_pkg::*;

    localparam int SL_W = COUNT_BITS + 1;

    logic [14:0]            r_left_max,   n_left_max;
    logic [14:0]            r_right_max,  n_right_max;
    logic [SL_W-1:0]        r_samples,    n_samples;
    logic [ACC_W-1:0]       r_acc,        n_acc;
    logic [COLUMN_BITS-1:0] r_column,     n_column;
    logic                   r_any,        n_any;

    logic [14:0]      left_mag, right_mag;
    logic [14:0]      left_upd, right_upd;
    logic             closes;
    logic [ACC_W:0]   acc_sum;
    logic             acc_carry;
    logic [ACC_W:0]   acc_next;
    logic [SL_W-1:0]  reload;

    // magnitudes and running peaks including the current sample
    assign left_mag  = pcm_magnitude(i_item.left_sample);
    assign right_mag = pcm_magnitude(i_item.right_sample);
    assign left_upd  = (left_mag > r_left_max) ? left_mag : r_left_max;
    assign right_upd = (i_cfg.stereo_mode && (right_mag > r_right_max)) ?
                       right_mag : r_right_max;

    // a sample closes the column when at most one is left to take
    assign closes = (r_samples[SL_W-1:1] == '0);

    // remainder accumulator step for the next column
    assign acc_sum   = {1'b0, r_acc} + (ACC_W+1)'(i_cfg.extra_step);
    assign acc_carry = (acc_sum >= (ACC_W+1)'(i_cfg.image_width));
    assign acc_next  = acc_carry ? (acc_sum - (ACC_W+1)'(i_cfg.image_width)) : acc_sum;
    assign reload    = {1'b0, i_base_count} + SL_W'(acc_carry);

    // result and handshake of the held item
    always_comb begin
        if (i_item.operation == OP_FLUSH) begin
            o_emit       = r_any;
            o_left_peak  = r_left_max;
            o_right_peak = i_cfg.stereo_mode ? r_right_max : 15'd0;
        end else begin
            o_emit       = closes;
            o_left_peak  = left_upd;
            o_right_peak = i_cfg.stereo_mode ? right_upd : 15'd0;
        end
    end

    assign o_column = r_column;
    assign o_taken  = i_valid && (!o_emit || i_out_free);

    // next state
    always_comb begin
        n_left_max  = r_left_max;
        n_right_max = r_right_max;
        n_samples   = r_samples;
        n_acc       = r_acc;
        n_column    = r_column;
        n_any       = r_any;
        if (i_item.operation == OP_FLUSH) begin
            n_left_max  = 15'd0;
            n_right_max = 15'd0;
            n_samples   = {1'b0, i_base_count};
            n_acc       = '0;
            n_column    = '0;
            n_any       = 1'b0;
        end else if (!closes) begin
            n_left_max  = left_upd;
            n_right_max = right_upd;
            n_samples   = r_samples - SL_W'(1);
            n_any       = 1'b1;
        end else begin
            n_left_max  = 15'd0;
            n_right_max = 15'd0;
            n_samples   = reload;
            n_acc       = acc_next[ACC_W-1:0];
            n_column    = r_column + COLUMN_BITS'(1);
            n_any       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_max  <= 15'd0;
            r_right_max <= 15'd0;
            r_samples   <= SL_W'(1);
            r_acc       <= '0;
            r_column    <= '0;
            r_any       <= 1'b0;
        end else if (o_taken) begin
            r_left_max  <= n_left_max;
            r_right_max <= n_right_max;
            r_samples   <= n_samples;
            r_acc       <= n_acc;
            r_column    <= n_column;
            r_any       <= n_any;
        end
    end

endmodule

`default_nettype wire

@@ design/spd_out_stage.sv @@
// result register of the decimator, holds one column report for the sink
// depends on spd_pkg
`default_nettype none

module spd_out_stage #(
    parameter int COLUMN_BITS = spd_pkg::COLUMN_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire logic [COLUMN_BITS-1:0] i_column,
    input  wire logic [14:0]            i_left_peak,
    input  wire logic [14:0]            i_right_peak,
    output logic                        o_free,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic      [COLUMN_BITS-1:0] o_column,
    output logic      [14:0]            o_left_peak,
    output logic      [14:0]            o_right_peak
);
    import spd_pkg::*;

    logic                   r_valid;
    logic [COLUMN_BITS-1:0] r_column;
    logic [14:0]            r_left_peak;
    logic [14:0]            r_right_peak;

    // slot is free when empty or being drained this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_column     <= i_column;
            r_left_peak  <= i_left_peak;
            r_right_peak <= i_right_peak;
        end
    end

    assign o_valid      = r_valid;
    assign o_column     = r_column;
    assign o_left_peak  = r_left_peak;
    assign o_right_peak = r_right_peak;

endmodule

`default_nettype wire

@@ design/stereo_peak_per_pixel_decimator.sv @@
// peak-per-pixel decimator: one item accepted per cycle while the report sink keeps up
// a column report passes the input register, then the result register, on its way
// to the master side; the core state updates as the held item is taken
// reset (synchronous, active low) empties both stages, restores register
// defaults and puts the block at the start of column zero
`default_nettype none

module stereo_peak_per_pixel_decimator #(
    parameter int COUNT_BITS  = spd_pkg::COUNT_BITS_DEF,
    parameter int COLUMN_BITS = spd_pkg::COLUMN_BITS_DEF,
    localparam int OUT_W      = ((COLUMN_BITS + 30 + 7) / 8) * 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // sample stream
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [31:0]                    i_s_tdata,  // left_sample, right_sample
    input  wire logic [0:0]                     i_s_tuser,  // operation
    // column reports
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic      [OUT_W-1:0]               o_m_tdata,  // column_index, left_peak,
                                                            // right_peak, zero pad
    // configuration writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [spd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [spd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import spd_pkg::*;

    logic [COUNT_BITS-1:0]  base_count;
    t_cfg                   cfg;
    t_in_item               s_item, held_item;
    logic                   held_valid;
    logic                   taken, emit, out_free;
    logic [COLUMN_BITS-1:0] core_column, out_column;
    logic [14:0]            core_left, core_right, out_left, out_right;

    assign o_cfg_ready = 1'b1;

    spd_cfg_regs #(.COUNT_BITS(COUNT_BITS)) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (i_cfg_valid),
        .i_index      (i_cfg_index),
        .i_data       (i_cfg_data),
        .o_base_count (base_count),
        .o_cfg        (cfg)
    );

    // unpack the incoming item
    assign s_item.operation    = i_s_tuser[0];
    assign s_item.left_sample  = i_s_tdata[15:0];
    assign s_item.right_sample = i_s_tdata[31:16];

    spd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (s_item),
        .o_valid (held_valid),
        .o_item  (held_item),
        .i_taken (taken)
    );

    spd_peak_core #(.COUNT_BITS(COUNT_BITS), .COLUMN_BITS(COLUMN_BITS)) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_base_count (base_count),
        .i_cfg        (cfg),
        .i_valid      (held_valid),
        .i_item       (held_item),
        .i_out_free   (out_free),
        .o_taken      (taken),
        .o_emit       (emit),
        .o_column     (core_column),
        .o_left_peak  (core_left),
        .o_right_peak (core_right)
    );

    spd_out_stage #(.COLUMN_BITS(COLUMN_BITS)) u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (taken && emit),
        .i_column     (core_column),
        .i_left_peak  (core_left),
        .i_right_peak (core_right),
        .o_free       (out_free),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_column     (out_column),
        .o_left_peak  (out_left),
        .o_right_peak (out_right)
    );

    // pack the report, zero padded to whole bytes
    assign o_m_tdata = OUT_W'({out_right, out_left, out_column});

endmodule

`default_nettype wire
